// ----- rtl/core/epsfe_pkg.sv -----
package epsfe_pkg;

   localparam int NUM_CODES   = 8;
   localparam int CODE_W      = 3;
   localparam int MS_W        = 16;
   localparam int MASK_W      = 8;
   localparam int LEVEL_W     = 16;
   localparam int QUOT_W      = 15;
   localparam int ELAPSED_W   = MS_W + 1;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [LEVEL_W-1:0] FULL_SCALE = LEVEL_W'(1) << QUOT_W;

   localparam logic [MS_W-1:0]   HOLD_MS_RESET    = 16'd2000;
   localparam logic [MS_W-1:0]   FADE_MS_RESET    = 16'd300;
   localparam logic [CODE_W-1:0] SLEEP_CODE_RESET = 3'd1;
   localparam logic [MASK_W-1:0] EYE_MASK_RESET   = 8'd28;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HOLD_MS    = 2'd0,
      CSR_FADE_MS    = 2'd1,
      CSR_SLEEP_CODE = 2'd2,
      CSR_EYE_MASK   = 2'd3
   } csr_index_type;

   localparam logic [CODE_W-1:0] CODE_NONE = '0;

endpackage

// ----- rtl/core/epsfe_req_if.sv -----
interface epsfe_req_if;
   import epsfe_pkg::*;

   logic              valid;
   logic              ready;
   logic              mode;
   logic [MS_W-1:0]   tick_ms;
   logic [CODE_W-1:0] request_code;

   modport source (output valid, output mode, output tick_ms, output request_code,
                   input ready);
   modport sink (input valid, input mode, input tick_ms, input request_code,
                 output ready);
endinterface

// ----- rtl/core/epsfe_rsp_if.sv -----
interface epsfe_rsp_if;
   import epsfe_pkg::*;

   logic               valid;
   logic               ready;
   logic [CODE_W-1:0]  active_code;
   logic [LEVEL_W-1:0] fade_level;
   logic               blink_pause;

   modport source (output valid, output active_code, output fade_level,
                   output blink_pause, input ready);
   modport sink (input valid, input active_code, input fade_level, input blink_pause,
                 output ready);
endinterface

// ----- rtl/core/epsfe_div.sv -----
module epsfe_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [epsfe_pkg::MS_W-1:0]    num,
   input  logic [epsfe_pkg::MS_W-1:0]    den,
   output logic                          done,
   output logic [epsfe_pkg::QUOT_W-1:0]  quot
);
   import epsfe_pkg::*;

   localparam int CNT_W = $clog2(QUOT_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [MS_W-1:0]   rem_ff, rem_in;
   logic [MS_W-1:0]   den_ff, den_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;

   logic [MS_W:0] rem_sh;
   logic [MS_W:0] rem_sub;
   logic          ge;

   always_comb begin
      rem_sh  = {rem_ff, 1'b0};
      ge      = rem_sh >= {1'b0, den_ff};
      rem_sub = rem_sh - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QUOT_W);
         rem_in  = num;
         den_in  = den;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? rem_sub[MS_W-1:0] : rem_sh[MS_W-1:0];
         quot_in = {quot_ff[QUOT_W-2:0], ge};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ----- rtl/core/exclusive_peak_slot_fade_envelope_top.sv -----
// Channel      Role    Signals                                   Transaction when
// req_chan     sink    mode, tick_ms, request_code               valid && ready
// rsp_chan     source  active_code, fade_level, blink_pause      valid && ready
// csr_*        write   csr_wr_en, csr_index, csr_wdata           csr_wr_en high
//
// A transaction without a fade ramp runs accept/update, classify and result;
// one with a ramp adds 15 steps of the shared restoring divider and the pickup
// of the quotient before the result. The divider computes one quotient bit per cycle.
// Synchronous reset empties the slot and loads the register defaults.
// The result waits in an output register; the next transaction is accepted
// meanwhile and holds at the result step until the previous one is taken.
module exclusive_peak_slot_fade_envelope_top (
   input  logic                               clock,
   input  logic                               reset,
   epsfe_req_if.sink                          req_chan,
   epsfe_rsp_if.source                        rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [epsfe_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [epsfe_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import epsfe_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [CODE_W-1:0]  slot_ff, slot_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic               down_ff, down_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [MS_W-1:0]    hold_ff, hold_in;
   logic [MS_W-1:0]    fade_ff, fade_in;
   logic [CODE_W-1:0]  sleep_ff, sleep_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]  rsp_code_ff, rsp_code_in;
   logic [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;
   logic               rsp_pause_ff, rsp_pause_in;

   logic                 div_start;
   logic [MS_W-1:0]      div_num;
   logic                 div_done;
   logic [QUOT_W-1:0]    div_quot;
   logic                 accept;
   logic [CODE_W-1:0]    req_code;
   logic [ELAPSED_W:0]   sum;
   logic [ELAPSED_W-1:0] e_adv;
   logic [ELAPSED_W-1:0] down_start;
   logic [ELAPSED_W-1:0] d_val;
   logic                 hold_ge_fade;

   epsfe_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (fade_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      req_code     = (int'(req_chan.request_code) < NUM_CODES) ?
                     req_chan.request_code : CODE_NONE;
      sum          = {1'b0, elapsed_ff} + (ELAPSED_W + 1)'(req_chan.tick_ms);
      e_adv        = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];
      hold_ge_fade = hold_ff >= fade_ff;
      down_start   = ELAPSED_W'(hold_ff) - ELAPSED_W'(fade_ff);
      d_val        = elapsed_ff - down_start;

      state_in     = state_ff;
      slot_in      = slot_ff;
      elapsed_in   = elapsed_ff;
      down_in      = down_ff;
      level_in     = level_ff;
      hold_in      = hold_ff;
      fade_in      = fade_ff;
      sleep_in     = sleep_ff;
      mask_in      = mask_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_code_in  = rsp_code_ff;
      rsp_level_in = rsp_level_ff;
      rsp_pause_in = rsp_pause_ff;
      div_start    = 1'b0;
      div_num      = elapsed_ff[MS_W-1:0];

      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_HOLD_MS:    hold_in  = csr_wdata[MS_W-1:0];
            CSR_FADE_MS:    fade_in  = csr_wdata[MS_W-1:0];
            CSR_SLEEP_CODE: sleep_in = csr_wdata[CODE_W-1:0];
            CSR_EYE_MASK:   mask_in  = csr_wdata[MASK_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_PREP;
               if (req_chan.mode) begin
                  slot_in = CODE_NONE;
               end else begin
                  elapsed_in = e_adv;
                  if (slot_ff == CODE_NONE) begin
                     if (req_code != CODE_NONE) begin
                        slot_in    = req_code;
                        elapsed_in = '0;
                     end
                  end else if (slot_ff == sleep_ff) begin
                     if (req_code != sleep_ff) begin
                        slot_in = CODE_NONE;
                     end
                  end else if (e_adv >= ELAPSED_W'(hold_ff)) begin
                     slot_in = CODE_NONE;
                  end
               end
            end
         end
         ST_PREP: begin
            state_in = ST_DONE;
            down_in  = 1'b0;
            if (slot_ff == CODE_NONE) begin
               level_in = '0;
            end else if (slot_ff == sleep_ff) begin
               level_in = FULL_SCALE;
            end else if (elapsed_ff < ELAPSED_W'(fade_ff)) begin
               div_start = 1'b1;
               div_num   = elapsed_ff[MS_W-1:0];
               state_in  = ST_DIV;
            end else if (hold_ge_fade && elapsed_ff >= down_start) begin
               if (d_val >= ELAPSED_W'(fade_ff)) begin
                  level_in = '0;
               end else begin
                  div_start = 1'b1;
                  div_num   = d_val[MS_W-1:0];
                  down_in   = 1'b1;
                  state_in  = ST_DIV;
               end
            end else begin
               level_in = FULL_SCALE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               level_in = down_ff ? FULL_SCALE - LEVEL_W'(div_quot) : LEVEL_W'(div_quot);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = slot_ff;
               rsp_level_in = level_ff;
               rsp_pause_in = (slot_ff != CODE_NONE) && mask_ff[slot_ff];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= CODE_NONE;
         hold_ff      <= HOLD_MS_RESET;
         fade_ff      <= FADE_MS_RESET;
         sleep_ff     <= SLEEP_CODE_RESET;
         mask_ff      <= EYE_MASK_RESET;
         rsp_valid_ff <= 1'b0;
         elapsed_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         hold_ff      <= hold_in;
         fade_ff      <= fade_in;
         sleep_ff     <= sleep_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
         elapsed_ff   <= elapsed_in;
      end
      down_ff      <= down_in;
      level_ff     <= level_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_level_ff <= rsp_level_in;
      rsp_pause_ff <= rsp_pause_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.active_code = rsp_code_ff;
   assign rsp_chan.fade_level  = rsp_level_ff;
   assign rsp_chan.blink_pause = rsp_pause_ff;

`ifndef SYNTH
   a_accept_to_prep: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_PREP)
      else $error("transaction not followed by classify step");

   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_level_ff <= FULL_SCALE)
      else $error("fade level above full scale");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_code_ff == CODE_NONE |-> rsp_level_ff == '0 && !rsp_pause_ff)
      else $error("empty slot reports nonzero level or pause");

   a_div_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside divide step");
`endif

endmodule

// ----- tb/sv/epsfe_envelope_checker.sv -----
`timescale 1ns / 1ps
module epsfe_envelope_checker (
   input  logic                              clock,
   input  logic                              reset,
   epsfe_req_if                              req_mon,
   epsfe_rsp_if                              rsp_mon,
   input  logic                              csr_wr_en,
   input  logic [epsfe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [epsfe_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                fail_count,
   output int                                open_count
);
   import epsfe_pkg::*;

   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic [LEVEL_W-1:0] level;
      logic               pause;
   } envelope_type;

   logic [63:0]        now_ms;
   logic [63:0]        claim_ms;
   logic [CODE_W-1:0]  held_code;
   logic [MS_W-1:0]    hold_len;
   logic [MS_W-1:0]    fade_len;
   logic [CODE_W-1:0]  sleep_sel;
   logic [MASK_W-1:0]  glyph_mask;
   envelope_type       expected_envelopes[$];
   int                 mismatches = 0;

   assign fail_count = mismatches;

   function automatic logic [LEVEL_W-1:0] ramp_level(input logic [63:0] num);
      if (fade_len == '0) begin
         return '0;
      end
      return LEVEL_W'((num * 64'(FULL_SCALE)) / 64'(fade_len));
   endfunction

   function automatic logic [LEVEL_W-1:0] envelope_level();
      logic [63:0] elapsed;
      logic [63:0] fall_at;
      logic [63:0] into_fall;
      elapsed = now_ms - claim_ms;
      if (held_code == CODE_NONE) begin
         return '0;
      end
      if (held_code == sleep_sel) begin
         return FULL_SCALE;
      end
      if (elapsed < 64'(fade_len)) begin
         return ramp_level(elapsed);
      end
      if (hold_len >= fade_len) begin
         fall_at = 64'(hold_len) - 64'(fade_len);
         if (elapsed >= fall_at) begin
            into_fall = elapsed - fall_at;
            if (into_fall >= 64'(fade_len)) begin
               return '0;
            end
            return FULL_SCALE - ramp_level(into_fall);
         end
      end
      return FULL_SCALE;
   endfunction

   function automatic envelope_type advance_slot(input logic m, input logic [MS_W-1:0] t,
                                                 input logic [CODE_W-1:0] c);
      envelope_type res;
      if (m) begin
         held_code = CODE_NONE;
      end else begin
         now_ms = now_ms + 64'(t);
         if (held_code == CODE_NONE) begin
            if (c != CODE_NONE) begin
               held_code = c;
               claim_ms  = now_ms;
            end
         end else if (held_code == sleep_sel) begin
            if (c != sleep_sel) begin
               held_code = CODE_NONE;
            end
         end else if (now_ms - claim_ms >= 64'(hold_len)) begin
            held_code = CODE_NONE;
         end
      end
      res.code  = held_code;
      res.level = envelope_level();
      res.pause = (held_code != CODE_NONE) ? glyph_mask[held_code] : 1'b0;
      return res;
   endfunction

   always @(posedge clock) begin
      envelope_type want;
      envelope_type seen;
      if (reset) begin
         now_ms     = '0;
         claim_ms   = '0;
         held_code  = CODE_NONE;
         hold_len   = HOLD_MS_RESET;
         fade_len   = FADE_MS_RESET;
         sleep_sel  = SLEEP_CODE_RESET;
         glyph_mask = EYE_MASK_RESET;
         expected_envelopes.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_HOLD_MS:    hold_len   = csr_wdata[MS_W-1:0];
               CSR_FADE_MS:    fade_len   = csr_wdata[MS_W-1:0];
               CSR_SLEEP_CODE: sleep_sel  = csr_wdata[CODE_W-1:0];
               CSR_EYE_MASK:   glyph_mask = csr_wdata[MASK_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_envelopes.push_back(advance_slot(req_mon.mode, req_mon.tick_ms,
                                                      req_mon.request_code));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.code  = rsp_mon.active_code;
            seen.level = rsp_mon.fade_level;
            seen.pause = rsp_mon.blink_pause;
            if (expected_envelopes.size() == 0) begin
               $error("unexpected transaction: active_code %0d fade_level %0d blink_pause %0d",
                      seen.code, seen.level, seen.pause);
               mismatches++;
            end else begin
               want = expected_envelopes.pop_front();
               if (seen.code !== want.code) begin
                  $error("active_code: expected %0d, got %0d", want.code, seen.code);
                  mismatches++;
               end
               if (seen.level !== want.level) begin
                  $error("fade_level: expected %0d, got %0d", want.level, seen.level);
                  mismatches++;
               end
               if (seen.pause !== want.pause) begin
                  $error("blink_pause: expected %0d, got %0d", want.pause, seen.pause);
                  mismatches++;
               end
            end
         end
      end
      open_count <= expected_envelopes.size();
   end

endmodule

// ----- tb/sv/tb_exclusive_peak_slot_fade_envelope_top.sv -----
`timescale 1ns / 1ps
module tb_exclusive_peak_slot_fade_envelope_top;
   import epsfe_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     fail_count;
   int                     open_count;
   int                     send_idle_pct;
   int                     rcv_idle_pct;
   logic                   starve_go;
   logic                   starve_done;
   int                     starve_left;
   logic [MS_W-1:0]        hold_cfg;
   logic [MS_W-1:0]        fade_cfg;
   logic [CODE_W-1:0]      sleep_cfg;

   epsfe_req_if req_chan();
   epsfe_rsp_if rsp_chan();

   always #10 clock = ~clock;

   exclusive_peak_slot_fade_envelope_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   epsfe_envelope_checker u_envelope_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .open_count (open_count)
   );

   // hold off the receiver for a long stretch once, else stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         starve_left    <= 0;
         starve_done    <= 1'b0;
      end else if (starve_go && !starve_done) begin
         rsp_chan.ready <= 1'b0;
         starve_left    <= 400;
         starve_done    <= 1'b1;
      end else if (starve_left != 0) begin
         rsp_chan.ready <= 1'b0;
         starve_left    <= starve_left - 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   task automatic send_item(input logic m, input logic [MS_W-1:0] t,
                            input logic [CODE_W-1:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.mode         <= m;
      req_chan.tick_ms      <= t;
      req_chan.request_code <= c;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (open_count != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic load_config(input logic [MS_W-1:0] h, input logic [MS_W-1:0] f,
                              input logic [CODE_W-1:0] s, input logic [MASK_W-1:0] g);
      hold_cfg  = h;
      fade_cfg  = f;
      sleep_cfg = s;
      csr_wr_en <= 1'b1;
      csr_index <= CSR_HOLD_MS;
      csr_wdata <= CSR_DATA_W'(h);
      @(posedge clock);
      csr_index <= CSR_FADE_MS;
      csr_wdata <= CSR_DATA_W'(f);
      @(posedge clock);
      csr_index <= CSR_SLEEP_CODE;
      csr_wdata <= CSR_DATA_W'(s);
      @(posedge clock);
      csr_index <= CSR_EYE_MASK;
      csr_wdata <= CSR_DATA_W'(g);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      #10_000_000;
      $display("exclusive_peak_slot_fade_envelope_top: mismatch");
      $finish;
   end

   initial begin
      int                seg;
      int                n;
      int                span;
      int                pick;
      logic              m;
      logic [MS_W-1:0]   t;
      logic [CODE_W-1:0] c;

      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.mode         <= 1'b0;
      req_chan.tick_ms      <= '0;
      req_chan.request_code <= CODE_NONE;
      csr_wr_en             <= 1'b0;
      csr_index             <= CSR_HOLD_MS;
      csr_wdata             <= '0;
      starve_go             <= 1'b0;
      rcv_idle_pct          <= 73;
      send_idle_pct = 36;
      hold_cfg      = HOLD_MS_RESET;
      fade_cfg      = FADE_MS_RESET;
      sleep_cfg     = SLEEP_CODE_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // default registers: claim, ramp up, plateau, ramp down, expiry, sleep, clear
      send_item(1'b0, 16'd0, CODE_NONE);
      send_item(1'b0, 16'd0, 3'd3);
      send_item(1'b0, 16'd150, 3'd5);
      send_item(1'b0, 16'd3, 3'd3);
      send_item(1'b0, 16'd1000, CODE_NONE);
      send_item(1'b0, 16'd700, CODE_NONE);
      send_item(1'b0, 16'd147, CODE_NONE);
      send_item(1'b0, 16'd0, 3'd1);
      send_item(1'b0, 16'hFFFF, 3'd1);
      send_item(1'b0, 16'd5, 3'd2);
      send_item(1'b0, 16'd0, 3'd7);
      send_item(1'b1, 16'hFFFF, 3'd7);
      send_item(1'b0, 16'd0, 3'd7);
      drain();

      // hold shorter than fade, sleep code zero
      load_config(16'd100, 16'd300, 3'd0, 8'hFF);
      send_item(1'b0, 16'd0, 3'd1);
      send_item(1'b0, 16'd50, 3'd0);
      send_item(1'b0, 16'd49, 3'd0);
      send_item(1'b0, 16'd1, 3'd0);
      drain();

      // zero hold and zero fade
      load_config(16'd0, 16'd0, 3'd7, 8'h00);
      send_item(1'b0, 16'd0, 3'd4);
      send_item(1'b0, 16'd0, CODE_NONE);
      send_item(1'b0, 16'd0, 3'd7);
      send_item(1'b0, 16'd0, 3'd7);
      send_item(1'b1, 16'd0, CODE_NONE);
      drain();

      load_config(16'hFFFF, 16'hFFFF, 3'd1, 8'hAA);
      send_item(1'b0, 16'd0, 3'd6);
      send_item(1'b0, 16'd32768, 3'd6);
      send_item(1'b0, 16'd32766, 3'd6);
      send_item(1'b0, 16'd1, 3'd6);

      for (seg = 0; seg < 12; seg++) begin
         drain();
         send_idle_pct = (seg < 4) ? 36 : (seg < 8) ? 73 : 0;
         rcv_idle_pct <= (seg < 4) ? 73 : (seg < 8) ? 36 : 0;
         case (seg % 4)
            0: load_config(16'($urandom_range(0, 300)), 16'($urandom_range(0, 150)),
                           3'($urandom_range(0, 7)), 8'($urandom));
            1: load_config(16'($urandom_range(500, 5000)), 16'($urandom_range(0, 1000)),
                           3'($urandom_range(0, 7)), 8'($urandom));
            2: load_config(16'($urandom_range(0, 1)) ^ ($urandom_range(0, 1) ? 16'hFFFF : 16'h0),
                           16'($urandom_range(0, 1)) ^ ($urandom_range(0, 1) ? 16'hFFFF : 16'h0),
                           3'($urandom_range(0, 7)), 8'($urandom));
            default: load_config(16'($urandom), 16'($urandom), 3'($urandom_range(0, 7)),
                                 8'($urandom));
         endcase
         span = int'(hold_cfg) / 8 + int'(fade_cfg) / 8 + 2;
         for (n = 0; n < 125; n++) begin
            if (seg == 9 && n == 40) begin
               starve_go <= 1'b1;
            end
            pick = $urandom_range(99);
            m = (pick < 3);
            t = (pick >= 95) ? 16'($urandom) : 16'($urandom_range(0, span));
            case ($urandom_range(4))
               0:       c = CODE_NONE;
               1, 2:    c = sleep_cfg;
               default: c = 3'($urandom);
            endcase
            send_item(m, t, c);
         end
      end
      drain();
      repeat (40) @(posedge clock);

      if (fail_count == 0 && open_count == 0) begin
         $display("exclusive_peak_slot_fade_envelope_top: match");
      end else begin
         $display("exclusive_peak_slot_fade_envelope_top: mismatch");
      end
      $finish;
   end

endmodule

// ----- exclusive_peak_slot_fade_envelope_top.f -----
rtl/core/epsfe_pkg.sv
rtl/core/epsfe_req_if.sv
rtl/core/epsfe_rsp_if.sv
rtl/core/epsfe_div.sv
rtl/core/exclusive_peak_slot_fade_envelope_top.sv
tb/sv/epsfe_envelope_checker.sv
tb/sv/tb_exclusive_peak_slot_fade_envelope_top.sv
